FILE: sv/lzsd_pkg.sv
// Shared types and constants for the LZSS stream decoder.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package lzsd_pkg;

  localparam int WIN_DEPTH = 4096;
  localparam int WIN_AW    = 12;
  localparam int LEN_W     = 5;   // match length 3..18
  localparam int FILL_W    = WIN_AW + 1;

  localparam logic [WIN_AW-1:0] START_POS = 12'hFEE;
  localparam logic [3:0]        LEN_BIAS  = 4'd3;

  // parse phase codes
  localparam logic [1:0] PH_FLAG   = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_MATCH2 = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       stream_done;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take;        // capture item, clear stream on new_stream
    logic load_flags;
    logic store_low;
    logic load_match;
    logic rd;          // window read at copy pointer
    logic emit_lit;
    logic emit_copy;
    logic adv_flag;
  } lzsd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] phase;
    logic       flag_lsb;
    logic       flag_empty;
    logic       over;
    logic       out_free;
    logic       copy_last;
    logic       hit_done;
  } lzsd_sts_t;

endpackage

FILE: sv/lzss_stream_decoder_top.sv
// LZSS decoder, 4 KiB window. Flag or first match byte: taken in S_IDLE, decoded in S_DECODE.
// Literal: decoded in S_DECODE into the output register once the output slot is free.
// Match of n bytes: S_MREAD, then S_COPY, one byte a cycle off the window read port while the output slot is free.
// Reset (rst_n, synchronous): parse state, counters and output_length cleared;
// window contents untouched, unwritten entries read as zero via a fill count.
`timescale 1ns / 1ps

module lzss_stream_decoder_top import lzsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  lzsd_cmd_t cmd;
  lzsd_sts_t sts;

  assign cfg_ready = 1'b1;

  lzsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzsd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .item      (in_item),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .sts       (sts)
  );

endmodule

FILE: sv/lzsd_ctrl.sv
// Sequencing FSM for the LZSS decoder: item intake, decode and match copy.
// Depends on lzsd_pkg; drives the datapath through lzsd_cmd_t.
`timescale 1ns / 1ps

module lzsd_ctrl import lzsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lzsd_sts_t sts,
  output lzsd_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_MREAD  = 2'd2;
  localparam logic [1:0] S_COPY   = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.over) begin
          state_nxt = S_IDLE;
        end else if (sts.phase == PH_DATA && !sts.flag_empty) begin
          if (sts.flag_lsb) begin
            if (sts.out_free) begin
              cmd.emit_lit = 1'b1;
              cmd.adv_flag = 1'b1;
              state_nxt    = S_IDLE;
            end
          end else begin
            cmd.store_low = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (sts.phase == PH_MATCH2) begin
          cmd.load_match = 1'b1;
          state_nxt      = S_MREAD;
        end else begin
          cmd.load_flags = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_MREAD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_COPY;
      end
      S_COPY: begin
        // emit one byte and prefetch the next while the output slot is free
        if (sts.out_free) begin
          cmd.emit_copy = 1'b1;
          if (sts.copy_last || sts.hit_done) begin
            cmd.adv_flag = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cmd.rd = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/lzsd_datapath.sv
// Datapath of the LZSS decoder: history window, parse state, counters, result register.
// Depends on lzsd_pkg; commanded by lzsd_ctrl.
`timescale 1ns / 1ps

module lzsd_datapath import lzsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lzsd_cmd_t cmd,
  input  in_item_t  item,
  input  logic      cfg_we,
  input  logic [31:0] cfg_data,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_item,
  output lzsd_sts_t sts
);

  logic [7:0]        win_mem [WIN_DEPTH];
  logic [7:0]        mem_q_r;

  logic [31:0]       out_len_r;
  logic [7:0]        item_byte_r;
  logic [WIN_AW-1:0] wr_pos_r, wr_pos_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [8:0]        flags_r, flags_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [7:0]        low_r;
  logic [31:0]       emitted_r, emitted_nxt;
  logic              finished_r, finished_nxt;
  logic [WIN_AW-1:0] src_r;
  logic [LEN_W-1:0]  rem_r;
  logic              fwd_r, rd_ok_r;
  logic [7:0]        fwd_byte_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              emit;
  logic [7:0]        ebyte, rd_byte;
  logic [32:0]       emitted_inc;
  logic [WIN_AW-1:0] rd_off;
  logic [8:0]        flags_sh;
  logic              fwd;

  assign emitted_inc = {1'b0, emitted_r} + 33'd1;
  assign rd_byte     = fwd_r ? fwd_byte_r : (rd_ok_r ? mem_q_r : 8'h00);
  assign emit        = cmd.emit_lit | cmd.emit_copy;
  assign ebyte       = cmd.emit_lit ? item_byte_r : rd_byte;
  assign rd_off      = src_r - START_POS;
  // same-cycle overlap: the byte being written is the one being read
  assign fwd         = cmd.rd & emit & (src_r == wr_pos_r);
  assign flags_sh    = flags_r >> 1;

  assign sts.phase      = phase_r;
  assign sts.flag_lsb   = flags_r[0];
  assign sts.flag_empty = (flags_r[8:1] == 8'h00);
  assign sts.over       = finished_r | (emitted_r >= out_len_r);
  assign sts.out_free   = ~out_valid_r | ~out_stall;
  assign sts.copy_last  = (rem_r == LEN_W'(1));
  assign sts.hit_done   = (emitted_inc >= {1'b0, out_len_r});

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    wr_pos_nxt   = wr_pos_r;
    fill_nxt     = fill_r;
    flags_nxt    = flags_r;
    phase_nxt    = phase_r;
    emitted_nxt  = emitted_r;
    finished_nxt = finished_r;
    if (cmd.take && item.new_stream) begin
      wr_pos_nxt   = START_POS;
      fill_nxt     = '0;
      flags_nxt    = '0;
      phase_nxt    = PH_FLAG;
      emitted_nxt  = '0;
      finished_nxt = 1'b0;
    end
    if (emit) begin
      wr_pos_nxt  = wr_pos_r + WIN_AW'(1);
      if (fill_r != FILL_W'(WIN_DEPTH)) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
      emitted_nxt = emitted_inc[31:0];
      if (sts.hit_done) begin
        finished_nxt = 1'b1;
      end
    end
    if (cmd.load_flags) begin
      flags_nxt = {1'b1, item_byte_r};
      phase_nxt = PH_DATA;
    end
    if (cmd.store_low) begin
      phase_nxt = PH_MATCH2;
    end
    if (cmd.adv_flag) begin
      flags_nxt = flags_sh;
      phase_nxt = (flags_sh[8:1] == 8'h00) ? PH_FLAG : PH_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_len_r   <= '0;
      wr_pos_r    <= START_POS;
      fill_r      <= '0;
      flags_r     <= '0;
      phase_r     <= PH_FLAG;
      emitted_r   <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        out_len_r <= cfg_data;
      end
      wr_pos_r   <= wr_pos_nxt;
      fill_r     <= fill_nxt;
      flags_r    <= flags_nxt;
      phase_r    <= phase_nxt;
      emitted_r  <= emitted_nxt;
      finished_r <= finished_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_byte_r <= item.in_byte;
    end
    if (cmd.store_low) begin
      low_r <= item_byte_r;
    end
    if (cmd.load_match) begin
      src_r <= {item_byte_r[7:4], low_r};
      rem_r <= LEN_W'(item_byte_r[3:0]) + LEN_W'(LEN_BIAS);
    end else begin
      if (cmd.rd) begin
        src_r <= src_r + WIN_AW'(1);
      end
      if (cmd.emit_copy) begin
        rem_r <= rem_r - LEN_W'(1);
      end
    end
    if (cmd.rd) begin
      fwd_r      <= fwd;
      fwd_byte_r <= ebyte;
      // entries not yet written since stream start read as zero
      rd_ok_r    <= ({1'b0, rd_off} < fill_r);
    end
    if (emit) begin
      out_item_r.out_byte    <= ebyte;
      out_item_r.run_end     <= cmd.emit_lit | sts.copy_last | sts.hit_done;
      out_item_r.stream_done <= sts.hit_done;
    end
  end

  // history window, read-old on a same-address write
  always_ff @(posedge clk) begin
    if (emit) begin
      win_mem[wr_pos_r] <= ebyte;
    end
    if (cmd.rd) begin
      mem_q_r <= win_mem[src_r];
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lzss_stream_decoder_top: directed and random LZSS streams,
// with a scoreboard class that decodes each accepted beat alongside the block.
// Depends on lzsd_pkg and the RTL top only.

module tb;
  import lzsd_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int LIMIT       = 600_000;
  localparam int SETTLE      = 24;
  localparam int PHASE_ITEMS = 75;

  // Tracks the decoder state and the bytes it still owes.
  class decode_scoreboard;
    logic [7:0]        window_mem [WIN_DEPTH];
    logic [WIN_AW-1:0] wr_pos;
    logic [8:0]        flags;
    logic [1:0]        phase;
    logic [7:0]        low_off;
    logic [31:0]       emitted;
    logic [31:0]       out_len;
    bit                finished;
    out_item_t         due_bytes[$];
    int                bad_bytes;
    int                checked;

    function new();
      out_len   = '0;
      bad_bytes = 0;
      checked   = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (window_mem[i]) window_mem[i] = '0;
      wr_pos   = START_POS;
      flags    = '0;
      phase    = PH_FLAG;
      low_off  = '0;
      emitted  = '0;
      finished = 1'b0;
    endfunction

    function bit over();
      return finished || (emitted >= out_len);
    endfunction

    function bit emit(logic [7:0] v);
      out_item_t r;
      window_mem[wr_pos] = v;
      wr_pos++;
      emitted++;
      r.out_byte    = v;
      r.run_end     = 1'b0;
      r.stream_done = (emitted >= out_len);
      due_bytes.push_back(r);
      if (r.stream_done) finished = 1'b1;
      return r.stream_done;
    endfunction

    function void next_flag();
      flags = flags >> 1;
      phase = (flags <= 9'd1) ? PH_FLAG : PH_DATA;
    endfunction

    // Returns 1 when the beat was decoded, 0 when the block ignores it.
    function bit take_byte(in_item_t it);
      int                first;
      int                n;
      logic [WIN_AW-1:0] src;
      if (it.new_stream) clear_stream();
      if (over()) return 1'b0;
      first = due_bytes.size();
      if (phase == PH_DATA && flags > 9'd1) begin
        if (flags[0]) begin
          void'(emit(it.in_byte));
          next_flag();
        end else begin
          low_off = it.in_byte;
          phase   = PH_MATCH2;
        end
      end else if (phase == PH_MATCH2) begin
        src = {it.in_byte[7:4], low_off};
        n   = int'(it.in_byte[3:0]) + int'(LEN_BIAS);
        // byte at a time, so an overlapping copy sees its own writes
        for (int i = 0; i < n; i++) begin
          if (emit(window_mem[src + WIN_AW'(i)])) break;
        end
        next_flag();
      end else begin
        flags = {1'b1, it.in_byte};
        phase = PH_DATA;
      end
      if (due_bytes.size() > first) due_bytes[due_bytes.size()-1].run_end = 1'b1;
      return 1'b1;
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      if (due_bytes.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got byte=%02h run_end=%0b done=%0b",
                 $time, got.out_byte, got.run_end, got.stream_done);
        bad_bytes++;
        return;
      end
      want = due_bytes.pop_front();
      checked++;
      if (got.out_byte !== want.out_byte || got.run_end !== want.run_end ||
          got.stream_done !== want.stream_done) begin
        $display("%0t: mismatch: expected byte=%02h run_end=%0b done=%0b, got byte=%02h run_end=%0b done=%0b",
                 $time, want.out_byte, want.run_end, want.stream_done,
                 got.out_byte, got.run_end, got.stream_done);
        bad_bytes++;
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_item_t    in_item   = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data  = '0;
  logic        in_stall;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_ready;

  decode_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int decoded_items = 0;
  int ignored_items = 0;
  int cfg_writes    = 0;
  int cycles        = 0;

  lzss_stream_decoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t: timeout, %0d bytes still owed", $time, sb.due_bytes.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= (int'($urandom_range(99)) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_byte(out_item);
  end

  task automatic send_byte(input logic [7:0] b, input logic ns);
    in_item_t it;
    it.in_byte    = b;
    it.new_stream = ns;
    @(negedge clk);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    if (sb.take_byte(it)) decoded_items++;
    else ignored_items++;
  endtask

  task automatic send_match(input logic [WIN_AW-1:0] src, input logic [3:0] nib);
    send_byte(src[7:0], 1'b0);
    send_byte({src[11:8], nib}, 1'b0);
  endtask

  task automatic wait_drained(input int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due_bytes.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_out_length(input logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.out_len = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One well-formed stream with random content, salted with stray beats.
  task automatic send_stream(input bit pause_mid);
    int                target;
    int                start;
    int                groups;
    logic [7:0]        flag_byte;
    logic [WIN_AW-1:0] src;
    target = $urandom_range(45, 12);
    start  = decoded_items;
    groups = 0;
    // the opening flag byte restarts the stream, so it goes out even if the last one ended
    while ((decoded_items - start) < target && (groups == 0 || !sb.over())) begin
      flag_byte = 8'($urandom);
      send_byte(flag_byte, groups == 0);
      for (int f = 0; f < 8 && !sb.over(); f++) begin
        if ($urandom_range(99) < 8)
          send_byte(8'($urandom), $urandom_range(5) == 0);
        else if (flag_byte[f])
          send_byte(8'($urandom), 1'b0);
        else begin
          // mostly near recent output, so copies pick up live data
          if ($urandom_range(3) == 0) src = WIN_AW'($urandom);
          else src = sb.wr_pos - WIN_AW'($urandom_range(40, 1));
          send_match(src, 4'($urandom));
        end
      end
      groups++;
      if (pause_mid && groups == 1) wait_drained(0);
    end
    if (sb.over()) send_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    int          mark;
    int          streams;
    logic [31:0] len;
    sb = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 29;
    recv_idle_pct = 74;

    // length still zero after reset: both beats ignored
    send_byte(8'hFF, 1'b1);
    send_byte(8'h41, 1'b0);
    wait_drained(SETTLE);
    write_out_length(32'hFFFF_FFFF);

    send_byte(8'hFF, 1'b1);  // all literals
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h00, 1'b0);  // all matches
    send_match(12'hFF5, 4'hF);  // self-overlapping run, writes wrap past the top
    send_match(START_POS, 4'h0);
    send_match(12'hFFE, 4'h5);  // read wraps
    send_match(12'h100, 4'h1);  // never-written area reads as zero
    wait_drained(SETTLE);

    // stop five output bytes in, partway through a match
    write_out_length(sb.emitted + 32'd5);
    send_byte(8'h00, 1'b0);
    send_match(sb.wr_pos - 12'd3, 4'hF);
    send_byte(8'h5A, 1'b0);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      mark    = decoded_items;
      streams = 0;
      while ((decoded_items - mark) < PHASE_ITEMS) begin
        wait_drained(SETTLE);
        case ($urandom_range(9))
          0:       len = 32'd1;
          1:       len = 32'hFFFF_FFFF;
          2:       len = 32'd0;
          default: len = $urandom_range(200, 5);
        endcase
        write_out_length(len);
        send_stream(streams == 1);
        streams++;
      end
    end

    wait_drained(SETTLE);
    $display("Covered %0d decoded and %0d ignored input beats; %0d output beats checked.",
             decoded_items, ignored_items, sb.checked);
    $display("Length written %0d times over three stall mixes, incl. overlap, wrap and cut-off.",
             cfg_writes);
    if (sb.bad_bytes == 0 && sb.due_bytes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
